/* rtl/sit_pkg.sv */
`timescale 1ns / 1ps
// shared constants and types for the segment intersection test
// no dependencies

package sit_pkg;

  // default coordinate width, signed Q12.4
  localparam int unsigned COORD_WIDTH_DEFAULT = 16;

  // orientation of an ordered point triple
  typedef enum logic [1:0] {
    TURN_COLLINEAR = 2'd0,
    TURN_CW        = 2'd1,
    TURN_CCW       = 2'd2
  } turn_e;

endpackage

/* rtl/sit_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces: segment pair requests and intersection results
// depends on sit_pkg for the default coordinate width

interface sit_pair_if #(
  parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_start_x;
  logic signed [COORD_WIDTH-1:0] first_start_y;
  logic signed [COORD_WIDTH-1:0] first_end_x;
  logic signed [COORD_WIDTH-1:0] first_end_y;
  logic signed [COORD_WIDTH-1:0] second_start_x;
  logic signed [COORD_WIDTH-1:0] second_start_y;
  logic signed [COORD_WIDTH-1:0] second_end_x;
  logic signed [COORD_WIDTH-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface sit_result_if;
  logic valid;
  logic ready;
  logic segments_meet;

  modport source (output valid, segments_meet, input ready);
  modport sink (input valid, segments_meet, output ready);
endinterface

/* rtl/sit_turn.sv */
`timescale 1ns / 1ps
// three-stage orientation unit: differences, exact cross products, sign
// depends on sit_pkg for the orientation code type

module sit_turn #(
  parameter int unsigned CoordW = sit_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  output sit_pkg::turn_e           turn_o
);

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned CrossW = ProdW + 1;

  logic signed [DiffW-1:0]  d_bay_d, d_cbx_d, d_bax_d, d_cby_d;
  logic signed [DiffW-1:0]  d_bay_q, d_cbx_q, d_bax_q, d_cby_q;
  logic signed [ProdW-1:0]  prod_l_d, prod_r_d;
  logic signed [ProdW-1:0]  prod_l_q, prod_r_q;
  logic signed [CrossW-1:0] cross_val;
  sit_pkg::turn_e           turn_d, turn_q;

  assign d_bay_d = DiffW'(by_i) - DiffW'(ay_i);
  assign d_cbx_d = DiffW'(cx_i) - DiffW'(bx_i);
  assign d_bax_d = DiffW'(bx_i) - DiffW'(ax_i);
  assign d_cby_d = DiffW'(cy_i) - DiffW'(by_i);

  assign prod_l_d = ProdW'(d_bay_q) * ProdW'(d_cbx_q);
  assign prod_r_d = ProdW'(d_bax_q) * ProdW'(d_cby_q);

  assign cross_val = CrossW'(prod_l_q) - CrossW'(prod_r_q);

  always_comb begin
    if (cross_val == '0) begin
      turn_d = sit_pkg::TURN_COLLINEAR;
    end else if (cross_val[CrossW-1]) begin
      turn_d = sit_pkg::TURN_CCW;
    end else begin
      turn_d = sit_pkg::TURN_CW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_bay_q  <= d_bay_d;
      d_cbx_q  <= d_cbx_d;
      d_bax_q  <= d_bax_d;
      d_cby_q  <= d_cby_d;
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
      turn_q   <= turn_d;
    end
  end

  assign turn_o = turn_q;

endmodule

/* rtl/segment_intersection_test_core.sv */
`timescale 1ns / 1ps
// segment intersection test top level: four orientation units and box checks
// depends on sit_pkg, sit_if (sit_pair_if, sit_result_if) and sit_turn
//
// usage:
//   pair_i carries one request: the two endpoints of each of two segments,
//   signed COORD_WIDTH-bit coordinates. result_o returns one bit per request,
//   segments_meet, set when the closed segments share at least one point.
//   results leave in request order.
// pipeline: four register stages; result_o.valid follows the request
//   through the stage valid bits to the output register.
//   stage 1 registers the coordinate differences and the bounding-box
//   checks, stage 2 the exact cross products, stage 3 the orientation
//   codes, stage 4 the combined result in the output register.
// throughput: one request per cycle when not stalled; the product stage sets the clock.
// reset: all stage valid bits clear, so result_o.valid is low and
//   pair_i.ready is high after reset.
// stall: when result_o.ready is low while a result waits, the whole pipe
//   holds and pair_i.ready drops; empty stages do not fill behind a result
//   that waits, and move again only once the output register is free.

module segment_intersection_test_core #(
  parameter int unsigned COORD_WIDTH = sit_pkg::COORD_WIDTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sit_pair_if.sink      pair_i,
  sit_result_if.source  result_o
);

  localparam int unsigned NumBox = 4;

  logic                 en;
  logic                 v1_q, v2_q, v3_q, vo_q;
  logic [NumBox-1:0]    box_d, box1_q, box2_q, box3_q;
  sit_pkg::turn_e       o1, o2, o3, o4;
  logic                 meet_d, meet_q;

  // m inside the closed box spanned by a and b along one axis
  function automatic logic in_span(input logic signed [COORD_WIDTH-1:0] a,
                                   input logic signed [COORD_WIDTH-1:0] m,
                                   input logic signed [COORD_WIDTH-1:0] b);
    in_span = ((m >= a) && (m <= b)) || ((m >= b) && (m <= a));
  endfunction

  assign en           = !vo_q || result_o.ready;
  assign pair_i.ready = en;

  always_comb begin
    box_d[0] = in_span(pair_i.first_start_x, pair_i.second_start_x, pair_i.first_end_x) &&
               in_span(pair_i.first_start_y, pair_i.second_start_y, pair_i.first_end_y);
    box_d[1] = in_span(pair_i.first_start_x, pair_i.second_end_x, pair_i.first_end_x) &&
               in_span(pair_i.first_start_y, pair_i.second_end_y, pair_i.first_end_y);
    box_d[2] = in_span(pair_i.second_start_x, pair_i.first_start_x, pair_i.second_end_x) &&
               in_span(pair_i.second_start_y, pair_i.first_start_y, pair_i.second_end_y);
    box_d[3] = in_span(pair_i.second_start_x, pair_i.first_end_x, pair_i.second_end_x) &&
               in_span(pair_i.second_start_y, pair_i.first_end_y, pair_i.second_end_y);
  end

  sit_turn #(.CoordW(COORD_WIDTH)) u_turn_1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .ax_i   (pair_i.first_start_x),
    .ay_i   (pair_i.first_start_y),
    .bx_i   (pair_i.first_end_x),
    .by_i   (pair_i.first_end_y),
    .cx_i   (pair_i.second_start_x),
    .cy_i   (pair_i.second_start_y),
    .turn_o (o1)
  );

  sit_turn #(.CoordW(COORD_WIDTH)) u_turn_2 (
    .clk_i  (clk_i),
    .en_i   (en),
    .ax_i   (pair_i.first_start_x),
    .ay_i   (pair_i.first_start_y),
    .bx_i   (pair_i.first_end_x),
    .by_i   (pair_i.first_end_y),
    .cx_i   (pair_i.second_end_x),
    .cy_i   (pair_i.second_end_y),
    .turn_o (o2)
  );

  sit_turn #(.CoordW(COORD_WIDTH)) u_turn_3 (
    .clk_i  (clk_i),
    .en_i   (en),
    .ax_i   (pair_i.second_start_x),
    .ay_i   (pair_i.second_start_y),
    .bx_i   (pair_i.second_end_x),
    .by_i   (pair_i.second_end_y),
    .cx_i   (pair_i.first_start_x),
    .cy_i   (pair_i.first_start_y),
    .turn_o (o3)
  );

  sit_turn #(.CoordW(COORD_WIDTH)) u_turn_4 (
    .clk_i  (clk_i),
    .en_i   (en),
    .ax_i   (pair_i.second_start_x),
    .ay_i   (pair_i.second_start_y),
    .bx_i   (pair_i.second_end_x),
    .by_i   (pair_i.second_end_y),
    .cx_i   (pair_i.first_end_x),
    .cy_i   (pair_i.first_end_y),
    .turn_o (o4)
  );

  // general case, then collinear endpoints that sit on the other segment
  assign meet_d = ((o1 != o2) && (o3 != o4)) ||
                  ((o1 == sit_pkg::TURN_COLLINEAR) && box3_q[0]) ||
                  ((o2 == sit_pkg::TURN_COLLINEAR) && box3_q[1]) ||
                  ((o3 == sit_pkg::TURN_COLLINEAR) && box3_q[2]) ||
                  ((o4 == sit_pkg::TURN_COLLINEAR) && box3_q[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= pair_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      box1_q <= box_d;
      box2_q <= box1_q;
      box3_q <= box2_q;
      meet_q <= meet_d;
    end
  end

  assign result_o.valid         = vo_q;
  assign result_o.segments_meet = meet_q;

endmodule

/* sim/segment_intersection_test_core_test.sv */
`timescale 1ns / 1ps
// self-checking bench for segment_intersection_test_core: directed and random segment pairs,
// each checked against an orientation-based intersection predictor
// depends on sit_pkg, sit_if and the core

module segment_intersection_test_core_test;

  localparam int unsigned CW = sit_pkg::COORD_WIDTH_DEFAULT;
  localparam int RANDOM_PAIRS = 750;
  localparam int QUIET_TAIL = 80;     // last requests go without idling
  localparam int DRAIN_CYCLES = 8;    // pipe is four deep
  localparam int STALL_LIMIT = 1000;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_pair_t;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  typedef struct {
    seg_pair_t pair;
    bit        meet;
  } meet_expect_t;

  logic clk_i;
  logic rst_ni;

  sit_pair_if #(.COORD_WIDTH(CW)) pair_bus ();
  sit_result_if result_bus ();

  segment_intersection_test_core #(.COORD_WIDTH(CW)) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pair_i   (pair_bus),
    .result_o (result_bus)
  );

  seg_pair_t    pending_pairs[$];
  meet_expect_t pending_meets[$];
  seg_pair_t    drive_pair;
  int           gap_left;
  int           stall_left;
  bit           src_busy;
  bit           sink_busy;
  int           mismatch_count;
  int           idle_cycles;

  assign pair_bus.first_start_x  = drive_pair.first_start_x;
  assign pair_bus.first_start_y  = drive_pair.first_start_y;
  assign pair_bus.first_end_x    = drive_pair.first_end_x;
  assign pair_bus.first_end_y    = drive_pair.first_end_y;
  assign pair_bus.second_start_x = drive_pair.second_start_x;
  assign pair_bus.second_start_y = drive_pair.second_start_y;
  assign pair_bus.second_end_x   = drive_pair.second_end_x;
  assign pair_bus.second_end_y   = drive_pair.second_end_y;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------- predictor

  function automatic sit_pkg::turn_e orientation(point_t a, point_t b, point_t c);
    longint cross_prod;
    cross_prod = (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
    if (cross_prod == 0) return sit_pkg::TURN_COLLINEAR;
    else if (cross_prod > 0) return sit_pkg::TURN_CW;
    else return sit_pkg::TURN_CCW;
  endfunction

  // closed bounding box spanned by a and b
  function automatic bit within_box(point_t a, point_t m, point_t b);
    return m.x <= ((a.x > b.x) ? a.x : b.x) && m.x >= ((a.x < b.x) ? a.x : b.x) &&
           m.y <= ((a.y > b.y) ? a.y : b.y) && m.y >= ((a.y < b.y) ? a.y : b.y);
  endfunction

  function automatic bit predict_meet(seg_pair_t p);
    point_t         p1, q1, p2, q2;
    sit_pkg::turn_e o1, o2, o3, o4;
    p1.x = p.first_start_x;  p1.y = p.first_start_y;
    q1.x = p.first_end_x;    q1.y = p.first_end_y;
    p2.x = p.second_start_x; p2.y = p.second_start_y;
    q2.x = p.second_end_x;   q2.y = p.second_end_y;
    o1 = orientation(p1, q1, p2);
    o2 = orientation(p1, q1, q2);
    o3 = orientation(p2, q2, p1);
    o4 = orientation(p2, q2, q1);
    return (o1 != o2 && o3 != o4) ||
           (o1 == sit_pkg::TURN_COLLINEAR && within_box(p1, p2, q1)) ||
           (o2 == sit_pkg::TURN_COLLINEAR && within_box(p1, q2, q1)) ||
           (o3 == sit_pkg::TURN_COLLINEAR && within_box(p2, p1, q2)) ||
           (o4 == sit_pkg::TURN_COLLINEAR && within_box(p2, q1, q2));
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_pair(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                          coord_t cx, coord_t cy, coord_t dx, coord_t dy);
    seg_pair_t p;
    p = '{ax, ay, bx, by, cx, cy, dx, dy};
    pending_pairs.push_back(p);
  endtask

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_near(int center, int span);
    int offset;
    offset = int'($urandom_range(0, 2 * span)) - span;
    return coord_t'(center + offset);
  endfunction

  task automatic fill_random();
    coord_t c[8];
    int     bx, by, dx, dy, reach, k;
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          foreach (c[i]) c[i] = coord_t'($urandom);
        end
        2, 3: begin
          // tiny grid, lots of collinear and touching cases
          foreach (c[i]) c[i] = pick_near(0, 6);
        end
        4, 5: begin
          // all four points on one line
          bx = int'($urandom_range(0, 2000)) - 1000;
          by = int'($urandom_range(0, 2000)) - 1000;
          dx = int'($urandom_range(0, 40)) - 20;
          dy = int'($urandom_range(0, 40)) - 20;
          for (int i = 0; i < 4; i++) begin
            k = int'($urandom_range(0, 60)) - 30;
            c[2*i]   = coord_t'(bx + k * dx);
            c[2*i+1] = coord_t'(by + k * dy);
          end
        end
        6, 7: begin
          // second start on or just past the first segment
          bx = int'($urandom_range(0, 2000)) - 1000;
          by = int'($urandom_range(0, 2000)) - 1000;
          dx = int'($urandom_range(0, 20)) - 10;
          dy = int'($urandom_range(0, 20)) - 10;
          reach = int'($urandom_range(1, 10));
          k = int'($urandom_range(0, 2 * reach + 4)) - 2;
          c[0] = coord_t'(bx);
          c[1] = coord_t'(by);
          c[2] = coord_t'(bx + 2 * reach * dx);
          c[3] = coord_t'(by + 2 * reach * dy);
          c[4] = coord_t'(bx + k * dx);
          c[5] = coord_t'(by + k * dy);
          c[6] = pick_near(bx + k * dx, 50);
          c[7] = pick_near(by + k * dy, 50);
        end
        8: begin
          foreach (c[i]) c[i] = pick_extreme();
        end
        default: begin
          // degenerate segments: each segment collapses to a point with even odds
          foreach (c[i]) c[i] = pick_near(0, 20);
          if ($urandom_range(0, 1)) begin
            c[2] = c[0];
            c[3] = c[1];
          end
          if ($urandom_range(0, 1)) begin
            c[6] = c[4];
            c[7] = c[5];
          end
        end
      endcase
      add_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin : driver
    seg_pair_t nxt;
    if (!rst_ni) begin
      pair_bus.valid <= 1'b0;
      gap_left <= 0;
      src_busy <= 1'b1;
    end else begin
      if (pair_bus.valid && pair_bus.ready)
        pending_meets.push_back('{drive_pair, predict_meet(drive_pair)});
      if ($urandom_range(0, 63) == 0)
        src_busy <= !src_busy;
      if (!pair_bus.valid || pair_bus.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          pair_bus.valid <= 1'b0;
        end else if (src_busy && pending_pairs.size() > QUIET_TAIL &&
                     $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 7);
          pair_bus.valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          nxt = pending_pairs.pop_front();
          drive_pair <= nxt;
          pair_bus.valid <= 1'b1;
        end else begin
          pair_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    meet_expect_t want;
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      stall_left <= 0;
      sink_busy <= 1'b1;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (pending_meets.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: segments_meet %0b", result_bus.segments_meet);
          mismatch_count++;
        end else begin
          want = pending_meets.pop_front();
          if (result_bus.segments_meet !== want.meet) begin
            if (mismatch_count < 10)
              $display("mismatch (%0d,%0d)-(%0d,%0d) / (%0d,%0d)-(%0d,%0d): exp %0b got %0b",
                       want.pair.first_start_x, want.pair.first_start_y,
                       want.pair.first_end_x, want.pair.first_end_y,
                       want.pair.second_start_x, want.pair.second_start_y,
                       want.pair.second_end_x, want.pair.second_end_y,
                       want.meet, result_bus.segments_meet);
            mismatch_count++;
          end
        end
      end
      if ($urandom_range(0, 63) == 0)
        sink_busy <= !sink_busy;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_bus.ready <= 1'b0;
      end else if (result_bus.ready && sink_busy && pending_pairs.size() > QUIET_TAIL &&
                   $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 7);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    if (!rst_ni || (pair_bus.valid && pair_bus.ready) ||
        (result_bus.valid && result_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("segment_intersection_test_core_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni = 1'b0;
    pair_bus.valid = 1'b0;
    result_bus.ready = 1'b0;
    drive_pair = '0;
    mismatch_count = 0;
    idle_cycles = 0;

    // crossing, parallel, collinear overlap and gap, touching, shared endpoint
    add_pair(0, 0, 16, 16, 0, 16, 16, 0);
    add_pair(0, 0, 16, 0, 0, 8, 16, 8);
    add_pair(0, 0, 32, 0, 16, 0, 48, 0);
    add_pair(0, 0, 16, 0, 32, 0, 48, 0);
    add_pair(0, 0, 32, 0, 16, 0, 16, 16);
    add_pair(0, 0, 16, 16, 16, 16, 32, 0);
    add_pair(0, 0, 16, 16, 32, 32, 48, 48);
    add_pair(0, 0, 0, 32, 0, 16, 0, 48);
    add_pair(0, 0, 16, 0, 16, 1, 32, 1);
    add_pair(-1, -1, 1, 1, -1, 1, 1, -1);
    // degenerate segments
    add_pair(0, 0, 32, 32, 16, 16, 16, 16);
    add_pair(0, 0, 32, 32, 16, 17, 16, 17);
    add_pair(5, 5, 5, 5, 5, 5, 5, 5);
    add_pair(5, 5, 5, 5, 6, 5, 6, 5);
    add_pair(-3, 7, -3, 7, -6, 4, 0, 10);
    // coordinate extremes
    add_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
             COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    add_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
             COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    add_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
             COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    add_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, COORD_MAX, COORD_MAX);
    add_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
             COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
    add_pair(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 0, COORD_MAX);
    add_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
             COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    add_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
             COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX);
    add_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
             COORD_MAX, COORD_MIN, COORD_MIN + 1, COORD_MAX - 1);
    fill_random();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do
      @(negedge clk_i);
    while (pending_pairs.size() != 0 || pair_bus.valid || pending_meets.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_meets.size() == 0)
      $display("segment_intersection_test_core_test: clean");
    else
      $display("segment_intersection_test_core_test: errors");
    $finish;
  end

endmodule
